// File: rtl/ttbof_pkg.sv
// shared types, codes and constants for the think-tag and brace-object framer
// no dependencies; imported by every module of the block
package ttbof_pkg;

  // section size caps, each section stores at most max-1 bytes
  localparam int REASON_MAX = 16384;
  localparam int OBJ_MAX    = 65536;
  localparam int RLEN_W     = 14;
  localparam int OLEN_W     = 16;
  localparam int CNT_W      = 16;

  // bundle queue between front and back, depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // results one text byte can cause at most
  localparam int MAX_RES = 3;

  // special characters
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [2:0] OPEN_LEN  = 3'd6;
  localparam logic [2:0] CLOSE_LEN = 3'd7;

  typedef enum logic [1:0] {
    TAG_IDLE    = 2'd0,
    TAG_OPENING = 2'd1,
    TAG_BODY    = 2'd2,
    TAG_CLOSING = 2'd3
  } tag_state_t;

  typedef enum logic [2:0] {
    KIND_RSN_BYTE = 3'd0,
    KIND_RSN_END  = 3'd1,
    KIND_OBJ_BYTE = 3'd2,
    KIND_OBJ_END  = 3'd3,
    KIND_OBJ_DROP = 3'd4,
    KIND_RSN_DROP = 3'd5
  } kind_t;

  typedef enum logic {
    FUNC_TEXT  = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_t;

  // input beat
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       token_last;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       out_byte;
    logic [CNT_W-1:0] byte_count;
    logic             last;
  } out_item_t;

  // one result inside a bundle
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] cnt;
  } slot_t;

  // all results of one input beat
  typedef struct packed {
    logic [1:0]          n;
    slot_t [MAX_RES-1:0] res;
  } bundle_t;

  // "think>" after the opening '<'
  function automatic logic [7:0] open_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h68;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6E;
      3'd4:    c = 8'h6B;
      3'd5:    c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "/think>" after the closing '<'
  function automatic logic [7:0] close_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h2F;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h68;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h6E;
      3'd5:    c = 8'h6B;
      3'd6:    c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/ttbof_front.sv
// front end: tag matcher and brace framer, one input beat per cycle while the queue has room
// depends on ttbof_pkg; produces one result bundle for the queue per beat that gives results
module ttbof_front
  import ttbof_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     q_push,
  input  logic     q_full,
  output bundle_t  q_data
);

  // framer state kept together
  typedef struct packed {
    logic              in_obj;
    logic [CNT_W-1:0]  depth;
    logic [OLEN_W-1:0] olen;
    logic              skip;
  } frame_st_t;

  typedef struct packed {
    frame_st_t        st;
    logic             emit;
    logic             close;
    logic [CNT_W-1:0] cnt;
  } frame_out_t;

  tag_state_t        tstate, tstate_next;
  logic [2:0]        tpos, tpos_next;
  logic [RLEN_W-1:0] rlen, rlen_next;
  frame_st_t         frame, frame_next;
  bundle_t           bundle;
  logic              accept;

  // one byte through the brace framer
  function automatic frame_out_t frame_apply(input frame_st_t st, input logic [7:0] c);
    frame_out_t r;
    r       = '0;
    r.st    = st;
    if (!st.in_obj) begin
      if (c == CH_LBRACE) begin
        r.st.in_obj = 1'b1;
        r.st.depth  = CNT_W'(1);
        r.st.olen   = OLEN_W'(1);
        r.emit      = 1'b1;
      end
    end else begin
      if (c == CH_LBRACE) begin
        if (st.depth != {CNT_W{1'b1}}) r.st.depth = st.depth + CNT_W'(1);
      end else if (c == CH_RBRACE) begin
        if (st.depth != '0) r.st.depth = st.depth - CNT_W'(1);
      end
      if ({1'b0, st.olen} < (OLEN_W + 1)'(OBJ_MAX - 1)) begin
        r.emit    = 1'b1;
        r.st.olen = st.olen + OLEN_W'(1);
      end
      if (r.st.depth == '0) begin
        r.close     = 1'b1;
        r.cnt       = CNT_W'(r.st.olen);
        r.st.in_obj = 1'b0;
        r.st.olen   = '0;
        r.st.skip   = 1'b1;
      end
    end
    return r;
  endfunction

  // append one result to a bundle
  function automatic bundle_t add_res(input bundle_t b, input kind_t k,
                                      input logic [7:0] d, input logic [CNT_W-1:0] c);
    bundle_t r;
    slot_t   s;
    r      = b;
    s.kind = k;
    s.data = d;
    s.cnt  = c;
    unique case (b.n)
      2'd0:    r.res[0] = s;
      2'd1:    r.res[1] = s;
      2'd2:    r.res[2] = s;
      default: ;
    endcase
    if (b.n != 2'd3) r.n = b.n + 2'd1;
    return r;
  endfunction

  // append what the framer gave for byte c
  function automatic bundle_t add_frame(input bundle_t b, input frame_out_t f,
                                        input logic [7:0] c);
    bundle_t r;
    r = b;
    if (f.emit)  r = add_res(r, KIND_OBJ_BYTE, c, '0);
    if (f.close) r = add_res(r, KIND_OBJ_END, 8'h00, f.cnt);
    return r;
  endfunction

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && (bundle.n != 2'd0);
  assign q_data = bundle;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= TAG_IDLE;
      tpos   <= '0;
      rlen   <= '0;
      frame  <= '0;
    end else if (accept) begin
      tstate <= tstate_next;
      tpos   <= tpos_next;
      rlen   <= rlen_next;
      frame  <= frame_next;
    end
  end

  // next state and result bundle
  always_comb begin
    frame_out_t fr1;
    frame_out_t fr2;
    logic [7:0] c;
    c           = item.data_byte;
    fr1         = '0;
    fr2         = '0;
    tstate_next = tstate;
    tpos_next   = tpos;
    rlen_next   = rlen;
    frame_next  = frame;
    bundle      = '0;

    if (item.func == FUNC_FLUSH) begin
      if (frame.in_obj) bundle = add_res(bundle, KIND_OBJ_DROP, 8'h00, CNT_W'(frame.olen));
      if (tstate == TAG_BODY || tstate == TAG_CLOSING)
        bundle = add_res(bundle, KIND_RSN_DROP, 8'h00, CNT_W'(rlen));
      tstate_next = TAG_IDLE;
      tpos_next   = '0;
      rlen_next   = '0;
      frame_next  = '0;
    end else if (!frame.skip) begin
      unique case (tstate)
        TAG_IDLE: begin
          if (c == CH_LT) begin
            tstate_next = TAG_OPENING;
            tpos_next   = '0;
          end else begin
            fr1        = frame_apply(frame, c);
            frame_next = fr1.st;
            bundle     = add_frame(bundle, fr1, c);
          end
        end
        TAG_OPENING: begin
          if (tpos < OPEN_LEN && c == open_char(tpos)) begin
            tpos_next = tpos + 3'd1;
            if (tpos + 3'd1 == OPEN_LEN) begin
              tstate_next = TAG_BODY;
              tpos_next   = '0;
              rlen_next   = '0;
            end
          end else begin
            // held '<' goes to the framer, then this byte
            tstate_next = TAG_IDLE;
            tpos_next   = '0;
            fr1         = frame_apply(frame, CH_LT);
            bundle      = add_frame(bundle, fr1, CH_LT);
            fr2         = frame_apply(fr1.st, c);
            bundle      = add_frame(bundle, fr2, c);
            frame_next  = fr2.st;
          end
        end
        TAG_BODY: begin
          if (c == CH_LT) begin
            tstate_next = TAG_CLOSING;
            tpos_next   = '0;
          end else if ({1'b0, rlen} < (RLEN_W + 1)'(REASON_MAX - 1)) begin
            bundle    = add_res(bundle, KIND_RSN_BYTE, c, '0);
            rlen_next = rlen + RLEN_W'(1);
          end
        end
        TAG_CLOSING: begin
          if (tpos < CLOSE_LEN && c == close_char(tpos)) begin
            tpos_next = tpos + 3'd1;
            if (tpos + 3'd1 == CLOSE_LEN) begin
              bundle      = add_res(bundle, KIND_RSN_END, 8'h00, CNT_W'(rlen));
              tstate_next = TAG_IDLE;
              tpos_next   = '0;
              rlen_next   = '0;
            end
          end else begin
            // the '<' was reasoning text after all
            tstate_next = TAG_BODY;
            tpos_next   = '0;
            if ({1'b0, rlen} < (RLEN_W + 1)'(REASON_MAX - 1)) begin
              bundle    = add_res(bundle, KIND_RSN_BYTE, CH_LT, '0);
              rlen_next = rlen + RLEN_W'(1);
            end
            if (c == CH_LT) begin
              tstate_next = TAG_CLOSING;
            end else if ({1'b0, rlen_next} < (RLEN_W + 1)'(REASON_MAX - 1)) begin
              bundle    = add_res(bundle, KIND_RSN_BYTE, c, '0);
              rlen_next = rlen_next + RLEN_W'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (item.func == FUNC_TEXT && item.token_last) frame_next.skip = 1'b0;
  end

`ifndef SYNTHESIS
  a_depth_open: assert property (@(posedge clk) disable iff (rst)
    frame.in_obj |-> frame.depth != '0)
    else $error("open object with zero brace depth");
  a_closed_len: assert property (@(posedge clk) disable iff (rst)
    !frame.in_obj |-> frame.olen == '0)
    else $error("object length kept after close");
  a_tag_pos: assert property (@(posedge clk) disable iff (rst)
    (tstate == TAG_OPENING |-> tpos < OPEN_LEN) and
    (tstate == TAG_CLOSING |-> tpos < CLOSE_LEN))
    else $error("tag position past end of tag");
`endif

endmodule

// File: rtl/ttbof_queue.sv
// short bundle queue between the front and back ends
// depends on ttbof_pkg; flop array with read and write pointers
module ttbof_queue
  import ttbof_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output bundle_t head,
  output logic    empty
);

  bundle_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr, rd;
  logic [QCNT_W-1:0] cnt;

  assign full  = (cnt == QCNT_W'(QDEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rd];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem[wr] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) wr <= wr + QPTR_W'(1);
      if (pop && !empty) rd <= rd + QPTR_W'(1);
      unique case ({push && !full, pop && !empty})
        2'b10:   cnt <= cnt + QCNT_W'(1);
        2'b01:   cnt <= cnt - QCNT_W'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("bundle pushed into full queue");
  a_nonempty_bundle: assert property (@(posedge clk) disable iff (rst)
    push |-> wdata.n != 2'd0)
    else $error("empty bundle queued");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> wr == rd)
    else $error("pointers disagree with fill count");
`endif

endmodule

// File: rtl/ttbof_back.sv
// back end: splits bundles into single result beats behind an output register
// depends on ttbof_pkg; pops the bundle queue as it loads the bundle's final result
module ttbof_back
  import ttbof_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  bundle_t   q_head,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic      out_valid;
  out_item_t out_reg;
  logic [1:0] idx;
  logic      load;
  logic      head_last;
  slot_t     cur;

  assign load      = !out_valid || pop;
  assign head_last = (idx == q_head.n - 2'd1);
  assign q_pop     = load && !q_empty && head_last;
  assign empty     = !out_valid;
  assign result    = out_reg;

  // pick the current slot of the head bundle
  always_comb begin
    unique case (idx)
      2'd0:    cur = q_head.res[0];
      2'd1:    cur = q_head.res[1];
      2'd2:    cur = q_head.res[2];
      default: cur = '0;
    endcase
  end

  // output register and slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) idx <= head_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_reg.kind       <= cur.kind;
      out_reg.out_byte   <= cur.data;
      out_reg.byte_count <= cur.cnt;
      out_reg.last       <= head_last;
    end
  end

`ifndef SYNTHESIS
  a_idx_needs_head: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> !q_empty)
    else $error("slot index set with no bundle waiting");
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx < q_head.n)
    else $error("slot index beyond bundle size");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_valid && out_reg.last)
    else $error("bundle popped without final beat");
`endif

endmodule

// File: rtl/think_tag_and_brace_object_framer_top.sv
// top level of the think-tag and brace-object framer
// depends on ttbof_pkg, ttbof_front, ttbof_queue and ttbof_back
//
//   channel   handshake        payload      direction
//   input     push / full      item         text and flush beats in
//   result    empty / pop      result       reasoning and object beats out
//
// one input beat per cycle while the bundle queue has room; each beat gives
// zero to three results, and while results are popped the back end drains one result per cycle
// a beat with several results holds back input only once the four-bundle
// queue between front and back fills
// reset (rst, synchronous) clears parser state, queue pointers and output valid
module think_tag_and_brace_object_framer_top
  import ttbof_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_wdata, q_head;

  // parser front end
  ttbof_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  // bundle queue
  ttbof_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  // result serializer
  ttbof_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the think-tag and brace-object framer
// depends on ttbof_pkg and think_tag_and_brace_object_framer_top; holds its own
// parser model in a scoreboard class, drives text and flush beats, checks result beats
`timescale 1ns / 1ps

module tb_top;
  import ttbof_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          REPORT_CAP   = 100;
  localparam logic [47:0] OPEN_TXT     = "think>";
  localparam logic [55:0] CLOSE_TXT    = "/think>";

  // parser model plus the queue of result beats still owed by the block
  class framer_scoreboard;
    tag_state_t        tag;
    logic [2:0]        pos;
    logic [RLEN_W-1:0] rsn_len;
    bit                in_obj;
    logic [15:0]       depth;
    logic [OLEN_W-1:0] obj_len;
    bit                skip;
    out_item_t         framed_results[$];
    out_item_t         step_beats[$];
    int                mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      tag     = TAG_IDLE;
      pos     = '0;
      rsn_len = '0;
      in_obj  = 1'b0;
      depth   = '0;
      obj_len = '0;
      skip    = 1'b0;
    endfunction

    function void emit(kind_t k, logic [7:0] b, logic [CNT_W-1:0] n);
      out_item_t r;
      if (step_beats.size() >= MAX_RES) return;
      r.kind       = k;
      r.out_byte   = b;
      r.byte_count = n;
      r.last       = 1'b0;
      step_beats.push_back(r);
    endfunction

    // reasoning bytes stop being stored once the section is full
    function void reason_byte(logic [7:0] c);
      if (int'(rsn_len) < REASON_MAX - 1) begin
        emit(KIND_RSN_BYTE, c, '0);
        rsn_len++;
      end
    endfunction

    function void body_byte(logic [7:0] c);
      if (c == CH_LT) begin
        tag = TAG_CLOSING;
        pos = '0;
      end else begin
        reason_byte(c);
      end
    endfunction

    // top-level object framing, braces keep counting once the object is full
    function void frame_byte(logic [7:0] c);
      if (!in_obj) begin
        if (c == CH_LBRACE) begin
          in_obj  = 1'b1;
          depth   = 16'd1;
          obj_len = 16'd1;
          emit(KIND_OBJ_BYTE, c, '0);
        end
        return;
      end
      if (c == CH_LBRACE) begin
        if (depth != 16'hFFFF) depth++;
      end else if (c == CH_RBRACE) begin
        if (depth != 16'd0) depth--;
      end
      if (int'(obj_len) < OBJ_MAX - 1) begin
        emit(KIND_OBJ_BYTE, c, '0);
        obj_len++;
      end
      if (depth == 16'd0) begin
        emit(KIND_OBJ_END, 8'h00, obj_len);
        in_obj  = 1'b0;
        obj_len = '0;
        skip    = 1'b1;
      end
    endfunction

    // work out the result beats of one accepted input beat
    function void predict_framing(in_item_t it);
      logic [7:0] c;
      c = it.data_byte;
      step_beats.delete();
      if (it.func == FUNC_FLUSH) begin
        if (in_obj) emit(KIND_OBJ_DROP, 8'h00, obj_len);
        if (tag == TAG_BODY || tag == TAG_CLOSING)
          emit(KIND_RSN_DROP, 8'h00, CNT_W'(rsn_len));
        clear_state();
      end else if (!skip) begin
        case (tag)
          TAG_IDLE: begin
            if (c == CH_LT) begin
              tag = TAG_OPENING;
              pos = '0;
            end else begin
              frame_byte(c);
            end
          end
          TAG_OPENING: begin
            if (pos < OPEN_LEN && c == OPEN_TXT[8*(5-int'(pos)) +: 8]) begin
              pos++;
              if (pos == OPEN_LEN) begin
                tag     = TAG_BODY;
                pos     = '0;
                rsn_len = '0;
              end
            end else begin
              // held '<' goes to the framer, the current byte is not a new tag start
              tag = TAG_IDLE;
              pos = '0;
              frame_byte(CH_LT);
              frame_byte(c);
            end
          end
          TAG_BODY: body_byte(c);
          default: begin
            if (pos < CLOSE_LEN && c == CLOSE_TXT[8*(6-int'(pos)) +: 8]) begin
              pos++;
              if (pos == CLOSE_LEN) begin
                emit(KIND_RSN_END, 8'h00, CNT_W'(rsn_len));
                tag     = TAG_IDLE;
                pos     = '0;
                rsn_len = '0;
              end
            end else begin
              // failed closing tag keeps its '<' as reasoning text
              tag = TAG_BODY;
              pos = '0;
              reason_byte(CH_LT);
              body_byte(c);
            end
          end
        endcase
      end
      if (it.func == FUNC_TEXT && it.token_last) skip = 1'b0;
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
      foreach (step_beats[i]) framed_results.push_back(step_beats[i]);
    endfunction

    function int pending();
      return framed_results.size();
    endfunction

    // compare one popped result beat against the oldest owed beat
    function void check_framed(out_item_t got);
      out_item_t want;
      if (framed_results.size() == 0) begin
        if (mismatches < REPORT_CAP)
          $error("unexpected result beat: kind %0d byte %0h count %0d last %0b",
                 got.kind, got.out_byte, got.byte_count, got.last);
        mismatches++;
        return;
      end
      want = framed_results.pop_front();
      if (got.kind !== want.kind) begin
        if (mismatches < REPORT_CAP)
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.out_byte !== want.out_byte) begin
        if (mismatches < REPORT_CAP)
          $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.byte_count !== want.byte_count) begin
        if (mismatches < REPORT_CAP)
          $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
        mismatches++;
      end
      if (got.last !== want.last) begin
        if (mismatches < REPORT_CAP)
          $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  item = '0;
  logic      empty;
  logic      pop  = 1'b0;
  out_item_t result;

  framer_scoreboard sb;
  in_item_t         plan[$];
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               cycle_count    = 0;

  think_tag_and_brace_object_framer_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check each popped beat, then pick the next pop at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_framed(result);
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void add_byte(logic [7:0] c, bit tl);
    in_item_t it;
    it.func       = FUNC_TEXT;
    it.data_byte  = c;
    it.token_last = tl;
    plan.push_back(it);
  endfunction

  // first n characters of s, each ending a token with the given odds
  function automatic void add_chars(string s, int tl_pct = 0, int n = 1 << 20);
    for (int i = 0; i < s.len() && i < n; i++)
      add_byte(s[i], $urandom_range(99) < tl_pct);
  endfunction

  function automatic void add_flush();
    in_item_t it;
    it.func       = FUNC_FLUSH;
    it.data_byte  = 8'($urandom_range(255));
    it.token_last = 1'($urandom_range(1));
    plan.push_back(it);
  endfunction

  function automatic logic [7:0] text_char();
    string pool;
    pool = "abkz :,\"019-/>";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  // random token stream built mostly from well-formed fragments
  function automatic void gen_random(int n);
    int start;
    int d;
    int r;
    start = plan.size();
    while (plan.size() - start < n) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          add_byte(CH_LBRACE, $urandom_range(99) < 25);
          d = 1;
          repeat ($urandom_range(8)) begin
            r = $urandom_range(5);
            if (r == 0 && d < 4) begin
              add_byte(CH_LBRACE, $urandom_range(99) < 25);
              d++;
            end else if (r == 1 && d > 1) begin
              add_byte(CH_RBRACE, $urandom_range(99) < 25);
              d--;
            end else begin
              add_byte(text_char(), $urandom_range(99) < 25);
            end
          end
          repeat (d) add_byte(CH_RBRACE, $urandom_range(99) < 25);
          repeat ($urandom_range(3)) add_byte(text_char(), $urandom_range(99) < 40);
        end
        3, 4: begin
          add_chars("<think>", 25);
          repeat ($urandom_range(10)) begin
            r = $urandom_range(5);
            if (r == 0) add_byte(CH_LT, 1'b0);
            else if (r == 1) add_chars("</think>", 25, $urandom_range(1, 7));
            else add_byte(text_char(), $urandom_range(99) < 25);
          end
          if ($urandom_range(4) != 0) add_chars("</think>", 25);
        end
        5: begin
          add_chars("<think>", 25, $urandom_range(1, 6));
          add_byte(8'($urandom_range(255)), $urandom_range(99) < 25);
        end
        6: repeat ($urandom_range(1, 5))
          add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        7: begin
          // abandoned object or reasoning section, then a flush
          if ($urandom_range(1)) begin
            add_byte(CH_LBRACE, 1'b0);
            repeat ($urandom_range(4)) add_byte(text_char(), 1'b0);
          end else begin
            add_chars("<think>x</think>", 25, $urandom_range(7, 13));
          end
          if ($urandom_range(1)) add_chars("{<think>", 0, $urandom_range(8));
          add_flush();
        end
        8: add_flush();
        default: begin
          add_byte(CH_LBRACE, 1'b0);
          add_chars("<think>", 25, $urandom_range(1, 7));
          add_byte(text_char(), 1'b0);
          add_byte(CH_RBRACE, $urandom_range(99) < 50);
        end
      endcase
    end
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.predict_framing(it);
  endtask

  task automatic run_plan();
    while (plan.size() > 0) send_item(plan.pop_front());
  endtask

  // hold input until every owed result has been popped
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes and bytes dropped after an object closes
    add_byte(CH_LBRACE, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(CH_RBRACE, 1'b0);
    add_byte("a", 1'b0);
    add_byte("b", 1'b1);
    // closing byte ends the token, so the next object is framed
    add_chars("{");
    add_byte(CH_RBRACE, 1'b1);
    // failed opening tag whose byte closes the object: three results
    add_chars("{<");
    add_byte(CH_RBRACE, 1'b0);
    add_byte("q", 1'b1);
    // '<' after '<', and matched tag letters lost
    add_chars("{<<t<thx");
    add_byte(CH_RBRACE, 1'b1);
    // failed closing tags, one of them on a second '<'
    add_chars("<think>a</x<</think>");
    // flush inside a reasoning body, then inside an object and a closing tag
    add_chars("<think>b");
    add_flush();
    add_chars("{<think>c<");
    add_flush();
    add_flush();
    run_plan();
    settle();

    // random token streams under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      gen_random(130);
      run_plan();
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
